// ===== hdl/dwrt_pkg.sv =====
// shared constants and controller/datapath interface types for the range tracker
`default_nettype none
package dwrt_pkg;

    localparam int WINDOW_DEPTH = 8;
    localparam int SAMPLE_W     = 24;
    localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int DATA_W       = 2 * SAMPLE_W;

    // commands from the controller to the datapath
    typedef struct packed {
        logic              accept;    // write new samples, advance slot
        logic              rd_en;     // read one window entry
        logic [SLOT_W-1:0] rd_addr;
        logic              rd_first;  // this read starts a fresh scan
        logic              out_load;  // capture the spreads into the output register
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic [SLOT_W-1:0] last_idx;  // highest valid slot for the current scan
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== hdl/dwrt_datapath.sv =====
// window storage, write slot, min/max scan registers and output payload
`default_nettype none
module dwrt_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire dwrt_pkg::t_dp_cmd                 i_cmd,
    input  wire logic [dwrt_pkg::SAMPLE_W-1:0]     i_accel,
    input  wire logic [dwrt_pkg::SAMPLE_W-1:0]     i_gyro,
    output dwrt_pkg::t_dp_stat                     o_stat,
    output logic [dwrt_pkg::SAMPLE_W-1:0]          o_accel_spread,
    output logic [dwrt_pkg::SAMPLE_W-1:0]          o_gyro_spread
);

    localparam logic [dwrt_pkg::SLOT_W-1:0] LastSlot =
        dwrt_pkg::SLOT_W'(dwrt_pkg::WINDOW_DEPTH - 1);

    logic [dwrt_pkg::SAMPLE_W-1:0] r_accel_mem [dwrt_pkg::WINDOW_DEPTH];
    logic [dwrt_pkg::SAMPLE_W-1:0] r_gyro_mem  [dwrt_pkg::WINDOW_DEPTH];

    logic [dwrt_pkg::SLOT_W-1:0]   r_slot;
    logic                          r_full;
    logic [dwrt_pkg::SLOT_W-1:0]   r_last_idx;

    logic [dwrt_pkg::SAMPLE_W-1:0] r_rd_accel;
    logic [dwrt_pkg::SAMPLE_W-1:0] r_rd_gyro;
    logic                          r_rd_vld;
    logic                          r_rd_first;

    logic [dwrt_pkg::SAMPLE_W-1:0] r_accel_lo;
    logic [dwrt_pkg::SAMPLE_W-1:0] r_accel_hi;
    logic [dwrt_pkg::SAMPLE_W-1:0] r_gyro_lo;
    logic [dwrt_pkg::SAMPLE_W-1:0] r_gyro_hi;

    logic [dwrt_pkg::SAMPLE_W-1:0] r_accel_spread;
    logic [dwrt_pkg::SAMPLE_W-1:0] r_gyro_spread;

    // memory write port, single read port per channel with registered data
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_accel_mem[r_slot] <= i_accel;
            r_gyro_mem[r_slot]  <= i_gyro;
        end
        if (i_cmd.rd_en) begin
            r_rd_accel <= r_accel_mem[i_cmd.rd_addr];
            r_rd_gyro  <= r_gyro_mem[i_cmd.rd_addr];
        end
    end

    // write slot, sticky full flag, last valid index and delayed read valid/first flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_full     <= 1'b0;
            r_last_idx <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_first <= 1'b0;
        end else begin
            r_rd_vld   <= i_cmd.rd_en;
            r_rd_first <= i_cmd.rd_first;
            if (i_cmd.accept) begin
                r_last_idx <= r_full ? LastSlot : r_slot;
                if (r_slot == LastSlot) begin
                    r_slot <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end
        end
    end

    // running min and max over the scanned entries
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if (r_rd_first) begin
                r_accel_lo <= r_rd_accel;
                r_accel_hi <= r_rd_accel;
                r_gyro_lo  <= r_rd_gyro;
                r_gyro_hi  <= r_rd_gyro;
            end else begin
                if (r_rd_accel < r_accel_lo) r_accel_lo <= r_rd_accel;
                if (r_rd_accel > r_accel_hi) r_accel_hi <= r_rd_accel;
                if (r_rd_gyro < r_gyro_lo)   r_gyro_lo  <= r_rd_gyro;
                if (r_rd_gyro > r_gyro_hi)   r_gyro_hi  <= r_rd_gyro;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_accel_spread <= r_accel_hi - r_accel_lo;
            r_gyro_spread  <= r_gyro_hi - r_gyro_lo;
        end
    end

    assign o_stat.last_idx = r_last_idx;
    assign o_accel_spread  = r_accel_spread;
    assign o_gyro_spread   = r_gyro_spread;

endmodule
`default_nettype wire

// ===== hdl/dwrt_ctrl.sv =====
// sequencer: accept, scan the valid window entries, hand off the result
`default_nettype none
module dwrt_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    input  wire dwrt_pkg::t_dp_stat   i_stat,
    output dwrt_pkg::t_dp_cmd         o_cmd
);

    localparam logic [1:0] StIdle   = 2'd0;
    localparam logic [1:0] StScan   = 2'd1;
    localparam logic [1:0] StFlush  = 2'd2;
    localparam logic [1:0] StFinish = 2'd3;

    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    logic [dwrt_pkg::SLOT_W-1:0] r_idx;
    logic [dwrt_pkg::SLOT_W-1:0] n_idx;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic                        out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_out_valid    = r_out_valid && !i_out_ready;
        o_in_ready     = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.rd_en    = 1'b0;
        o_cmd.rd_addr  = r_idx;
        o_cmd.rd_first = (r_idx == '0);
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            StIdle: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_idx        = '0;
                    n_state      = StScan;
                end
            end
            StScan: begin
                o_cmd.rd_en = 1'b1;
                if (r_idx == i_stat.last_idx) begin
                    n_state = StFlush;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            StFlush: begin
                n_state = StFinish;
            end
            StFinish: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = StIdle;
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== hdl/dual_window_range_tracker_top.sv =====
// top level of the dual window range tracker
`default_nettype none
// Each input transfer carries an acceleration and a gyro magnitude (unsigned
// Q8.16). Both samples are written into two circular windows of
// dwrt_pkg::WINDOW_DEPTH entries at a shared write slot, the slot advances with
// wraparound, and after the scan one output transfer returns, per channel, the
// maximum minus the minimum over the valid entries: the entries written so far
// until the first wrap, the whole window after it. After acceptance the controller
// reads the valid entries in turn through the single read port of each window,
// a flush state lets the last read reach the min/max registers, and the spreads
// are loaded into the output register once it is free. A new input is taken
// only when the previous scan is finished, while the last result may still
// wait in the output register for the downstream side.
module dual_window_range_tracker_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input stream
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [dwrt_pkg::DATA_W-1:0]   i_s_axis_tdata,  // [23:0] accel_magnitude,
                                                                // [47:24] gyro_magnitude
    // result stream
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [dwrt_pkg::DATA_W-1:0]        o_m_axis_tdata   // [23:0] accel_spread,
                                                                // [47:24] gyro_spread
);

    dwrt_pkg::t_dp_cmd             cmd;
    dwrt_pkg::t_dp_stat            stat;
    logic [dwrt_pkg::SAMPLE_W-1:0] accel_spread;
    logic [dwrt_pkg::SAMPLE_W-1:0] gyro_spread;

    // sequencing and output valid
    dwrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // windows, min/max tracking and result payload
    dwrt_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_accel        (i_s_axis_tdata[dwrt_pkg::SAMPLE_W-1:0]),
        .i_gyro         (i_s_axis_tdata[dwrt_pkg::DATA_W-1:dwrt_pkg::SAMPLE_W]),
        .o_stat         (stat),
        .o_accel_spread (accel_spread),
        .o_gyro_spread  (gyro_spread)
    );

    // pack results, first field in the low bits
    assign o_m_axis_tdata = {gyro_spread, accel_spread};

endmodule
`default_nettype wire

// ===== tb/dual_window_range_tracker_top_tb.sv =====
// self-checking testbench for the dual window range tracker, directed table then random samples
module dual_window_range_tracker_top_tb;
    import dwrt_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 400000;
    // settle time after the last result, sized from the window depth plus margin
    localparam int DRAIN_CYCLES = 2 + WINDOW_DEPTH + 10;

    localparam bit [SAMPLE_W-1:0] ALL_ONES = {SAMPLE_W{1'b1}};

    // one pair of spreads, gyro in the upper half as on the result bus
    typedef struct packed {
        bit [SAMPLE_W-1:0] gyro;
        bit [SAMPLE_W-1:0] accel;
    } spread_pair_t;

    // directed stimulus row; fixed_exp marks rows whose spreads are typed in
    typedef struct packed {
        bit                fixed_exp;
        bit [SAMPLE_W-1:0] accel_in;
        bit [SAMPLE_W-1:0] gyro_in;
        bit [SAMPLE_W-1:0] accel_exp;
        bit [SAMPLE_W-1:0] gyro_exp;
    } sample_row_t;

    localparam int NUM_ROWS = 18;
    localparam sample_row_t SAMPLE_ROWS [NUM_ROWS] = '{
        // single valid entry gives zero spreads
        '{1'b1, 24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000},
        // both extremes present in each channel
        '{1'b1, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF},
        '{1'b1, 24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF},
        // alternating and mixed bit patterns
        '{1'b0, 24'hAAAAAA, 24'h555555, 24'h000000, 24'h000000},
        '{1'b0, 24'h555555, 24'hAAAAAA, 24'h000000, 24'h000000},
        '{1'b0, 24'h123456, 24'h654321, 24'h000000, 24'h000000},
        '{1'b0, 24'h000001, 24'hFFFFFE, 24'h000000, 24'h000000},
        // eighth write wraps the slot and fills the window
        '{1'b0, 24'h7FFFFF, 24'h800000, 24'h000000, 24'h000000},
        // overwrite all slots but the last with one value, extremes age out
        '{1'b0, 24'h400000, 24'h400000, 24'h000000, 24'h000000},
        '{1'b0, 24'h400000, 24'h400000, 24'h000000, 24'h000000},
        '{1'b0, 24'h400000, 24'h400000, 24'h000000, 24'h000000},
        '{1'b0, 24'h400000, 24'h400000, 24'h000000, 24'h000000},
        '{1'b0, 24'h400000, 24'h400000, 24'h000000, 24'h000000},
        '{1'b0, 24'h400000, 24'h400000, 24'h000000, 24'h000000},
        '{1'b0, 24'h400000, 24'h400000, 24'h000000, 24'h000000},
        // full window of equal values
        '{1'b1, 24'h400000, 24'h400000, 24'h000000, 24'h000000},
        // one lsb either side of the plateau
        '{1'b1, 24'h400001, 24'h3FFFFF, 24'h000001, 24'h000001},
        '{1'b0, 24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000}
    };

    logic              i_clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_valid = 1'b0;
    logic [DATA_W-1:0] s_data = '0;
    logic              s_ready;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [DATA_W-1:0] m_data;

    // window copies kept by the predictor
    bit [SAMPLE_W-1:0] accel_window [WINDOW_DEPTH];
    bit [SAMPLE_W-1:0] gyro_window  [WINDOW_DEPTH];
    int unsigned       next_slot = 0;
    bit                window_wrapped = 1'b0;

    spread_pair_t      pending_spreads [$];
    spread_pair_t      oldest_spreads;
    spread_pair_t      got_spreads;
    int unsigned       error_count = 0;
    int unsigned       cycle_count = 0;
    int unsigned       send_idle_pct = 28;
    int unsigned       recv_idle_pct = 77;
    bit [SAMPLE_W-1:0] cluster_base = '0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    dual_window_range_tracker_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [23:0] accel_magnitude, [47:24] gyro_magnitude
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)    // [23:0] accel_spread, [47:24] gyro_spread
    );

    // max minus min over the first count entries
    function automatic bit [SAMPLE_W-1:0] window_spread(
        input bit [SAMPLE_W-1:0] win [WINDOW_DEPTH],
        input int unsigned count
    );
        bit [SAMPLE_W-1:0] lo;
        bit [SAMPLE_W-1:0] hi;
        lo = win[0];
        hi = win[0];
        for (int k = 1; k < count; k++) begin
            if (win[k] < lo) lo = win[k];
            if (win[k] > hi) hi = win[k];
        end
        return hi - lo;
    endfunction

    // write both samples, advance the slot, return the spreads over the valid entries
    function automatic spread_pair_t update_windows(
        input bit [SAMPLE_W-1:0] accel,
        input bit [SAMPLE_W-1:0] gyro
    );
        spread_pair_t pair;
        int unsigned  count;
        accel_window[next_slot] = accel;
        gyro_window[next_slot]  = gyro;
        next_slot++;
        if (next_slot == WINDOW_DEPTH) begin
            next_slot      = 0;
            window_wrapped = 1'b1;
        end
        count      = window_wrapped ? WINDOW_DEPTH : next_slot;
        pair.accel = window_spread(accel_window, count);
        pair.gyro  = window_spread(gyro_window, count);
        return pair;
    endfunction

    // mostly full-range values, some clustered near a drifting base, a few rails
    function automatic bit [SAMPLE_W-1:0] random_magnitude();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick <= 5) return SAMPLE_W'($urandom());
        if (pick <= 8) return cluster_base + SAMPLE_W'($urandom_range(255));
        return $urandom_range(1) ? ALL_ONES : '0;
    endfunction

    // present one sample and hold it until the transfer, then record its spreads
    task automatic send_sample(
        input bit [SAMPLE_W-1:0] accel,
        input bit [SAMPLE_W-1:0] gyro,
        input bit                fixed_exp,
        input spread_pair_t      typed_spreads
    );
        spread_pair_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {gyro, accel};
        do @(posedge i_clk); while (!s_ready);
        predicted = update_windows(accel, gyro);
        pending_spreads.push_back(fixed_exp ? typed_spreads : predicted);
    endtask

    // receiver: random backpressure, compare every result transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_valid && m_ready) begin
                got_spreads = m_data;
                if (pending_spreads.size() == 0) begin
                    $display("%0t: unexpected result accel %h gyro %h", $time,
                             got_spreads.accel, got_spreads.gyro);
                    error_count++;
                end else begin
                    oldest_spreads = pending_spreads.pop_front();
                    if (got_spreads.accel !== oldest_spreads.accel) begin
                        $display("%0t: accel_spread expected %h got %h", $time,
                                 oldest_spreads.accel, got_spreads.accel);
                        error_count++;
                    end
                    if (got_spreads.gyro !== oldest_spreads.gyro) begin
                        $display("%0t: gyro_spread expected %h got %h", $time,
                                 oldest_spreads.gyro, got_spreads.gyro);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        spread_pair_t typed_spreads;
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, sender sparse-idle and receiver heavy-stall
        for (int r = 0; r < NUM_ROWS; r++) begin
            typed_spreads.accel = SAMPLE_ROWS[r].accel_exp;
            typed_spreads.gyro  = SAMPLE_ROWS[r].gyro_exp;
            send_sample(SAMPLE_ROWS[r].accel_in, SAMPLE_ROWS[r].gyro_in,
                        SAMPLE_ROWS[r].fixed_exp, typed_spreads);
        end

        // random samples in three idle phases
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct = 77;
                recv_idle_pct = 28;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n % 16 == 0) cluster_base = SAMPLE_W'($urandom());
            send_sample(random_magnitude(), random_magnitude(), 1'b0, '0);
        end
        s_valid <= 1'b0;

        // drain outstanding results, then let the block settle
        while (pending_spreads.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/dwrt_pkg.sv
hdl/dwrt_datapath.sv
hdl/dwrt_ctrl.sv
hdl/dual_window_range_tracker_top.sv
tb/dual_window_range_tracker_top_tb.sv
